>>> rtl/core/pulse_rate_estimator_display_core_defines.svh
// ---------------------------------------------------------------------------
// pulse rate estimator display core defines
// assertion macros for the core rtl, empty under synthesis
// ---------------------------------------------------------------------------
`ifndef PULSE_RATE_ESTIMATOR_DISPLAY_CORE_DEFINES_SVH
`define PULSE_RATE_ESTIMATOR_DISPLAY_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define PRED_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pred assertion failed");

// next-cycle implication, checked out of reset
`define PRED_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pred assertion failed");

`else

`define PRED_ASSERT_NOW(lbl, ante, cons)
`define PRED_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> rtl/core/pred_pkg.sv
// ---------------------------------------------------------------------------
// pred_pkg
// shared widths, register indexes, reset values, control types and glyph table
// ---------------------------------------------------------------------------
`default_nettype none

package pred_pkg;

  localparam int SampleW     = 16;
  localparam int CountW      = 8;
  localparam int CfgW        = 16;
  localparam int IndexW      = 3;
  localparam int RowW        = 8;
  localparam int NumRows     = 5;
  localparam int GlyphW      = 3;

  // rate divider: (numerator << 8) / ticks, two quotient bits per cycle
  localparam int DivW        = SampleW + 8;
  localparam int BitsPerStep = 2;
  localparam int DivSteps    = DivW / BitsPerStep;
  localparam int StepW       = $clog2(DivSteps);

  localparam logic [IndexW-1:0] RegQuietLow   = 3'd0;
  localparam logic [IndexW-1:0] RegQuietHigh  = 3'd1;
  localparam logic [IndexW-1:0] RegIdleEnter  = 3'd2;
  localparam logic [IndexW-1:0] RegIdleResume = 3'd3;
  localparam logic [IndexW-1:0] RegFallLimit  = 3'd4;
  localparam logic [IndexW-1:0] RegRiseLimit  = 3'd5;
  localparam logic [IndexW-1:0] RegNumerator  = 3'd6;

  localparam logic [SampleW-1:0] QuietLowReset   = 16'd30100;
  localparam logic [SampleW-1:0] QuietHighReset  = 16'd30250;
  localparam logic [CountW-1:0]  IdleEnterReset  = 8'd30;
  localparam logic [CountW-1:0]  IdleResumeReset = 8'd10;
  localparam logic [CountW-1:0]  FallLimitReset  = 8'd4;
  localparam logic [CountW-1:0]  RiseLimitReset  = 8'd6;
  localparam logic [SampleW-1:0] NumeratorReset  = 16'd2000;

  localparam logic [CountW-1:0]  CountMax        = 8'd255;

  typedef struct packed {
    logic accept;
    logic eval;
    logic div_step;
    logic filt;
    logic load;
  } pred_cmd_t;

  typedef struct packed {
    logic beat;
  } pred_sts_t;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    sat_inc = (v == CountMax) ? CountMax : v + 8'd1;
  endfunction

  // five 3-bit rows per digit, row 0 in the low bits; bit2 = left column
  function automatic logic [NumRows*GlyphW-1:0] glyph(input logic [3:0] d);
    case (d)
      4'd0:    glyph = {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
      4'd1:    glyph = {3'd2, 3'd2, 3'd2, 3'd2, 3'd2};
      4'd2:    glyph = {3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
      4'd3:    glyph = {3'd7, 3'd1, 3'd7, 3'd1, 3'd7};
      4'd4:    glyph = {3'd1, 3'd1, 3'd7, 3'd5, 3'd5};
      4'd5:    glyph = {3'd7, 3'd1, 3'd7, 3'd4, 3'd7};
      4'd6:    glyph = {3'd7, 3'd5, 3'd7, 3'd4, 3'd7};
      4'd7:    glyph = {3'd2, 3'd2, 3'd2, 3'd1, 3'd7};
      4'd8:    glyph = {3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
      4'd9:    glyph = {3'd7, 3'd1, 3'd7, 3'd5, 3'd7};
      default: glyph = '0;
    endcase
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/pred_ctrl.sv
// ---------------------------------------------------------------------------
// pred_ctrl
// sequencer for one sample: evaluate, divide on a beat, filter, load output
// ---------------------------------------------------------------------------
`default_nettype none

module pred_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire pred_pkg::pred_sts_t  sts,
  output pred_pkg::pred_cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EVAL = 5'b00010,
    S_DIV  = 5'b00100,
    S_FILT = 5'b01000,
    S_LOAD = 5'b10000
  } state_t;

  state_t                       state;
  state_t                       state_next;
  logic [pred_pkg::StepW-1:0]   step_cnt;
  logic                         slot_free;

  assign in_stall  = (state != S_IDLE);
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = sts.beat ? S_DIV : S_FILT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step_cnt == pred_pkg::StepW'(pred_pkg::DivSteps - 1)) begin
          state_next = S_FILT;
        end
      end
      S_FILT: begin
        cmd.filt   = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (slot_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DIV) begin
        step_cnt <= step_cnt + pred_pkg::StepW'(1);
      end else begin
        step_cnt <= '0;
      end
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/pred_datapath.sv
// ---------------------------------------------------------------------------
// pred_datapath
// config registers, tracking state, radix-4 rate divider, lag filter, glyph rows
// ---------------------------------------------------------------------------
`default_nettype none

module pred_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write_en,
  input  wire logic [pred_pkg::IndexW-1:0]   cfg_index,
  input  wire logic [pred_pkg::CfgW-1:0]     cfg_data,
  input  wire logic [pred_pkg::SampleW-1:0]  sample,
  input  wire pred_pkg::pred_cmd_t           cmd,
  output pred_pkg::pred_sts_t                sts,
  output logic [pred_pkg::CountW-1:0]        rate_shown,
  output logic                               echo_valid,
  output logic [pred_pkg::SampleW-1:0]       echo_sample,
  output logic [pred_pkg::RowW-1:0]          row_a,
  output logic [pred_pkg::RowW-1:0]          row_b,
  output logic [pred_pkg::RowW-1:0]          row_c,
  output logic [pred_pkg::RowW-1:0]          row_d,
  output logic [pred_pkg::RowW-1:0]          row_e
);

  localparam int CW = pred_pkg::CountW;
  localparam int SW = pred_pkg::SampleW;
  localparam int DW = pred_pkg::DivW;

  // configuration
  logic [SW-1:0] band_low;
  logic [SW-1:0] band_high;
  logic [CW-1:0] idle_enter;
  logic [CW-1:0] idle_resume;
  logic [CW-1:0] fall_limit;
  logic [CW-1:0] rise_limit;
  logic [SW-1:0] rate_numerator;

  // tracking state
  logic [SW-1:0] sample_reg;
  logic [SW-1:0] previous_sample;
  logic [CW-1:0] quiet_run;
  logic          idle_mode;
  logic          filter_primed;
  logic          rising_phase;
  logic [CW-1:0] rise_count;
  logic [CW-1:0] fall_count;
  logic [CW-1:0] beat_ticks;
  logic [CW-1:0] rate_value;
  logic          trk_reg;
  logic          beat_reg;
  logic [CW-1:0] shown_reg;

  // divider
  logic [DW-1:0] quo;
  logic [CW-1:0] rem;
  logic [CW-1:0] div_d;
  logic [DW-1:0] quo_step;
  logic [CW-1:0] rem_step;
  logic [CW:0]   trial;

  // evaluate
  logic          quiet;
  logic          rose;
  logic          trk;
  logic          beat;
  logic          rise_end;
  logic [CW-1:0] qr_new;
  logic [CW-1:0] rise_new;
  logic [CW-1:0] fall_new;
  logic [CW-1:0] bt_new;

  // filter
  logic [CW-1:0]   rate_first;
  logic [CW+1:0]   rate_x3;
  logic [DW:0]     mix;
  logic [CW-1:0]   rate_mixed;
  logic [CW-1:0]   rate_new;

  // display
  logic [1:0]      hundreds;
  logic [6:0]      rem100;
  logic [14:0]     tens_prod;
  logic [3:0]      tens;
  logic [6:0]      ones_full;
  logic [3:0]      ones;
  logic [pred_pkg::NumRows*pred_pkg::GlyphW-1:0] tens_glyph;
  logic [pred_pkg::NumRows*pred_pkg::GlyphW-1:0] ones_glyph;
  logic [pred_pkg::RowW-1:0] row_line [pred_pkg::NumRows];

  always_ff @(posedge clk) begin
    if (rst) begin
      band_low       <= pred_pkg::QuietLowReset;
      band_high      <= pred_pkg::QuietHighReset;
      idle_enter     <= pred_pkg::IdleEnterReset;
      idle_resume    <= pred_pkg::IdleResumeReset;
      fall_limit     <= pred_pkg::FallLimitReset;
      rise_limit     <= pred_pkg::RiseLimitReset;
      rate_numerator <= pred_pkg::NumeratorReset;
    end else if (cfg_write_en) begin
      case (cfg_index)
        pred_pkg::RegQuietLow:   band_low       <= cfg_data;
        pred_pkg::RegQuietHigh:  band_high      <= cfg_data;
        pred_pkg::RegIdleEnter:  idle_enter     <= cfg_data[CW-1:0];
        pred_pkg::RegIdleResume: idle_resume    <= cfg_data[CW-1:0];
        pred_pkg::RegFallLimit:  fall_limit     <= cfg_data[CW-1:0];
        pred_pkg::RegRiseLimit:  rise_limit     <= cfg_data[CW-1:0];
        pred_pkg::RegNumerator:  rate_numerator <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    quiet    = (sample_reg > band_low) && (sample_reg < band_high);
    rose     = sample_reg > previous_sample;
    qr_new   = quiet ? pred_pkg::sat_inc(quiet_run) : '0;
    trk      = idle_mode ? (qr_new < idle_resume) : (qr_new < idle_enter);
    rise_new = (rose && rising_phase) ? pred_pkg::sat_inc(rise_count) : rise_count;
    fall_new = (!rose && !rising_phase) ? pred_pkg::sat_inc(fall_count) : fall_count;
    bt_new   = pred_pkg::sat_inc(beat_ticks);
    beat     = trk && !rising_phase && (fall_new > fall_limit);
    rise_end = rising_phase && (rise_new > rise_limit);
  end

  assign sts.beat = beat;

  // restoring division, BitsPerStep quotient bits per cycle
  always_comb begin
    rem_step = rem;
    quo_step = quo;
    trial    = '0;
    for (int i = 0; i < pred_pkg::BitsPerStep; i++) begin
      trial    = {rem_step, quo_step[DW-1]};
      quo_step = {quo_step[DW-2:0], 1'b0};
      if (trial >= {1'b0, div_d}) begin
        rem_step    = CW'(trial - {1'b0, div_d});
        quo_step[0] = 1'b1;
      end else begin
        rem_step = trial[CW-1:0];
      end
    end
  end

  // first beat takes the raw rate, later ones a quarter new plus three quarters old
  always_comb begin
    rate_first = (quo[DW-1:8] > SW'(pred_pkg::CountMax)) ? pred_pkg::CountMax
                                                          : quo[CW+7:8];
    rate_x3    = {1'b0, rate_value, 1'b0} + {2'b00, rate_value};
    mix        = {1'b0, quo} + {(DW + 1 - CW - 10)'(0), rate_x3, 8'd0};
    rate_mixed = (mix[DW:10] > (DW - 9)'(pred_pkg::CountMax)) ? pred_pkg::CountMax
                                                               : mix[CW+9:10];
    rate_new   = filter_primed ? rate_mixed : rate_first;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= '0;
      quiet_run       <= '0;
      idle_mode       <= 1'b1;
      filter_primed   <= 1'b0;
      rising_phase    <= 1'b0;
      rise_count      <= '0;
      fall_count      <= '0;
      beat_ticks      <= '0;
      rate_value      <= '0;
    end else if (cmd.eval) begin
      previous_sample <= sample_reg;
      quiet_run       <= qr_new;
      if (trk) begin
        idle_mode  <= 1'b0;
        rise_count <= rise_new;
        fall_count <= fall_new;
        beat_ticks <= bt_new;
        if (beat) begin
          rising_phase <= 1'b1;
          fall_count   <= '0;
          beat_ticks   <= '0;
        end else if (rise_end) begin
          rising_phase <= 1'b0;
          rise_count   <= '0;
        end
      end else begin
        idle_mode     <= 1'b1;
        filter_primed <= 1'b0;
      end
    end else if (cmd.filt && beat_reg) begin
      rate_value    <= rate_new;
      filter_primed <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_reg <= sample;
    end
    if (cmd.eval) begin
      trk_reg  <= trk;
      beat_reg <= beat;
      quo      <= {rate_numerator, 8'd0};
      rem      <= '0;
      div_d    <= bt_new;
    end
    if (cmd.div_step) begin
      quo <= quo_step;
      rem <= rem_step;
    end
    if (cmd.filt) begin
      shown_reg <= !trk_reg ? '0 : (beat_reg ? rate_new : rate_value);
    end
  end

  // decimal digits: tens by multiply with 205/2048, exact below 100
  always_comb begin
    if (shown_reg >= 8'd200) begin
      hundreds = 2'd2;
      rem100   = 7'(shown_reg - 8'd200);
    end else if (shown_reg >= 8'd100) begin
      hundreds = 2'd1;
      rem100   = 7'(shown_reg - 8'd100);
    end else begin
      hundreds = 2'd0;
      rem100   = shown_reg[6:0];
    end
    tens_prod  = {8'd0, rem100} * 15'd205;
    tens       = tens_prod[14:11];
    ones_full  = rem100 - ({3'd0, tens} * 7'd10);
    ones       = ones_full[3:0];
    tens_glyph = pred_pkg::glyph(tens);
    ones_glyph = pred_pkg::glyph(ones);
    for (int r = 0; r < pred_pkg::NumRows; r++) begin
      row_line[r] = {ones_glyph[pred_pkg::GlyphW*r],
                     (hundreds == 2'd1),
                     1'b0,
                     tens_glyph[pred_pkg::GlyphW*r +: pred_pkg::GlyphW],
                     ones_glyph[pred_pkg::GlyphW*r+1 +: 2]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rate_shown  <= shown_reg;
      echo_valid  <= trk_reg;
      echo_sample <= trk_reg ? sample_reg : '0;
      row_a       <= row_line[0];
      row_b       <= row_line[1];
      row_c       <= row_line[2];
      row_d       <= row_line[3];
      row_e       <= row_line[4];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/pulse_rate_estimator_display_core.sv
// ---------------------------------------------------------------------------
// pulse_rate_estimator_display_core
// pulse rate estimator with a two-digit 3x5 glyph readout
// ---------------------------------------------------------------------------
// usage
//   input channel in_valid/in_stall carries one sensor sample per beat; the
//   output channel out_valid/out_stall carries one result per sample: shown
//   rate, echo flag and sample, and five glyph rows (bit 6 = hundreds dot)
//   a sample is taken only while the sequencer is idle, so one sample is in
//   work at a time; a sample without a heartbeat passes the evaluate, filter
//   and load steps, one that completes a heartbeat also passes the 24-bit
//   rate divider between evaluate and filter, which retires two quotient
//   bits per cycle
//   the result sits in an output register, so the next sample is taken while
//   the receiver holds out_stall; if a new result is ready and the register
//   is still full, the sequencer waits in its load step until the beat goes
//   reset (rst, synchronous) restores the register defaults and clears the
//   tracking state to idle; config writes (cfg_write_en/cfg_index/cfg_data)
//   are taken in any cycle and meant for an idle block
// ---------------------------------------------------------------------------
`default_nettype none
`include "pulse_rate_estimator_display_core_defines.svh"

module pulse_rate_estimator_display_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write_en,
  input  wire logic [pred_pkg::IndexW-1:0]   cfg_index,
  input  wire logic [pred_pkg::CfgW-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [pred_pkg::SampleW-1:0]  sample,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [pred_pkg::CountW-1:0]        rate_shown,
  output logic                               echo_valid,
  output logic [pred_pkg::SampleW-1:0]       echo_sample,
  output logic [pred_pkg::RowW-1:0]          row_a,
  output logic [pred_pkg::RowW-1:0]          row_b,
  output logic [pred_pkg::RowW-1:0]          row_c,
  output logic [pred_pkg::RowW-1:0]          row_d,
  output logic [pred_pkg::RowW-1:0]          row_e
);

  pred_pkg::pred_cmd_t cmd;
  pred_pkg::pred_sts_t sts;

  pred_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pred_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample       (sample),
    .cmd          (cmd),
    .sts          (sts),
    .rate_shown   (rate_shown),
    .echo_valid   (echo_valid),
    .echo_sample  (echo_sample),
    .row_a        (row_a),
    .row_b        (row_b),
    .row_c        (row_c),
    .row_d        (row_d),
    .row_e        (row_e)
  );

  // idle results show nothing
  `PRED_ASSERT_NOW(a_idle_blank, out_valid && !echo_valid, (rate_shown == 8'd0) && (echo_sample == 16'd0))

  // hundreds dot follows the shown rate
  `PRED_ASSERT_NOW(a_dot_match, out_valid, row_a[6] == ((rate_shown >= 8'd100) && (rate_shown < 8'd200)))

  // one sample in work at a time
  `PRED_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall)

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the pulse rate estimator display core. Samples go
// in through a queue-fed driver with random gaps. Each accepted sample runs
// through an internal model of the estimator: quiet band, idle and tracking,
// rise and fall phases, filtered rate, and glyph rows. The monitor checks
// every result against the oldest expected one under random output stalls,
// over several register settings that include the extremes.
// ---------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic [7:0]  rate_shown;
    logic        echo_valid;
    logic [15:0] echo_sample;
    logic [7:0]  row_a;
    logic [7:0]  row_b;
    logic [7:0]  row_c;
    logic [7:0]  row_d;
    logic [7:0]  row_e;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [pred_pkg::IndexW-1:0] cfg_index = '0;
  logic [pred_pkg::CfgW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [pred_pkg::SampleW-1:0] sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [pred_pkg::CountW-1:0] rate_shown;
  logic echo_valid;
  logic [pred_pkg::SampleW-1:0] echo_sample;
  logic [pred_pkg::RowW-1:0] row_a, row_b, row_c, row_d, row_e;

  pulse_rate_estimator_display_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .rate_shown   (rate_shown),
    .echo_valid   (echo_valid),
    .echo_sample  (echo_sample),
    .row_a        (row_a),
    .row_b        (row_b),
    .row_c        (row_c),
    .row_d        (row_d),
    .row_e        (row_e)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register mirror
  logic [15:0] band_low, band_high, numerator;
  logic [7:0]  enter_len, resume_len, fall_lim, rise_lim;

  // estimator model state
  logic [15:0] prev_seen;
  logic [7:0]  quiet_len, rises, falls, ticks_since_beat, rate_est;
  logic        idle_now, filter_ready, in_rise;

  logic [15:0] sample_q[$];
  reading_t    reading_q[$];

  int queued_count = 0;
  int accepted_count = 0;
  int checked_count = 0;
  int mismatch_count = 0;
  int beats_timed = 0;
  int dotted_count = 0;
  int settings_count = 1;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  int hold_req = 0;
  int hold_done = 0;
  bit sender_free = 1'b0;
  bit receiver_free = 1'b0;

  logic [15:0] opening_samples [22] = '{
    16'd65535, 16'd60000, 16'd50000, 16'd40000, 16'd30000, 16'd20000, 16'd10000,
    16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7,
    16'd30100, 16'd30101, 16'd30249, 16'd30250, 16'd65534, 16'd1, 16'd0
  };

  function automatic logic [7:0] bump(input logic [7:0] v);
    bump = (v == 8'hff) ? 8'hff : v + 8'd1;
  endfunction

  function automatic logic [7:0] clip8(input logic [31:0] v);
    clip8 = (v > 32'd255) ? 8'hff : v[7:0];
  endfunction

  // row 0 in the top bits; bit2 of each row is the left column
  function automatic logic [14:0] digit_rows(input logic [3:0] d);
    case (d)
      4'd0:    digit_rows = {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
      4'd1:    digit_rows = {3'd2, 3'd2, 3'd2, 3'd2, 3'd2};
      4'd2:    digit_rows = {3'd7, 3'd1, 3'd7, 3'd4, 3'd7};
      4'd3:    digit_rows = {3'd7, 3'd1, 3'd7, 3'd1, 3'd7};
      4'd4:    digit_rows = {3'd5, 3'd5, 3'd7, 3'd1, 3'd1};
      4'd5:    digit_rows = {3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
      4'd6:    digit_rows = {3'd7, 3'd4, 3'd7, 3'd5, 3'd7};
      4'd7:    digit_rows = {3'd7, 3'd1, 3'd2, 3'd2, 3'd2};
      4'd8:    digit_rows = {3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
      4'd9:    digit_rows = {3'd7, 3'd5, 3'd7, 3'd1, 3'd7};
      default: digit_rows = '0;
    endcase
  endfunction

  function automatic reading_t predict_reading(input logic [15:0] s);
    reading_t    rd;
    logic [15:0] prior;
    logic        tracking;
    logic [7:0]  shown;
    logic [31:0] q8;
    logic [7:0]  hund, tens, ones;
    logic [14:0] tens_rows, ones_rows;
    logic [2:0]  tg, og;
    logic [39:0] rows_all;
    prior = prev_seen;
    prev_seen = s;
    if (s > band_low && s < band_high) quiet_len = bump(quiet_len);
    else quiet_len = 8'd0;
    tracking = idle_now ? (quiet_len < resume_len) : (quiet_len < enter_len);
    shown = 8'd0;
    if (tracking) begin
      idle_now = 1'b0;
      if (s > prior) begin
        if (in_rise) rises = bump(rises);
      end else begin
        if (!in_rise) falls = bump(falls);
      end
      ticks_since_beat = bump(ticks_since_beat);
      if (!in_rise && falls > fall_lim) begin
        q8 = {8'd0, numerator, 8'd0} / {24'd0, ticks_since_beat};
        if (!filter_ready) begin
          filter_ready = 1'b1;
          rate_est = clip8(q8 >> 8);
        end else begin
          rate_est = clip8((q8 + 32'd768 * {24'd0, rate_est}) >> 10);
        end
        in_rise = 1'b1;
        falls = 8'd0;
        ticks_since_beat = 8'd0;
        beats_timed++;
      end else if (rises > rise_lim && in_rise) begin
        in_rise = 1'b0;
        rises = 8'd0;
      end
      shown = rate_est;
    end else begin
      idle_now = 1'b1;
      filter_ready = 1'b0;
    end
    hund = shown / 8'd100;
    tens = (shown / 8'd10) % 8'd10;
    ones = shown % 8'd10;
    if (hund == 8'd1) dotted_count++;
    tens_rows = digit_rows(tens[3:0]);
    ones_rows = digit_rows(ones[3:0]);
    for (int r = 0; r < 5; r++) begin
      tg = tens_rows[14-3*r -: 3];
      og = ones_rows[14-3*r -: 3];
      rows_all[39-8*r -: 8] = {og[0], hund == 8'd1, 1'b0, tg, og[2:1]};
    end
    rd.rate_shown = shown;
    rd.echo_valid = tracking;
    rd.echo_sample = tracking ? s : 16'd0;
    {rd.row_a, rd.row_b, rd.row_c, rd.row_d, rd.row_e} = rows_all;
    return rd;
  endfunction

  function automatic int pick_gap(input bit free_run);
    int r;
    r = $urandom_range(0, 99);
    if (free_run || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("[%0t] result %0d %s: got %0d, expected %0d",
             $time, checked_count, what, got, want);
  endtask

  // driver: predict on each accepted beat, then offer the next sample
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
      band_low = pred_pkg::QuietLowReset;
      band_high = pred_pkg::QuietHighReset;
      enter_len = pred_pkg::IdleEnterReset;
      resume_len = pred_pkg::IdleResumeReset;
      fall_lim = pred_pkg::FallLimitReset;
      rise_lim = pred_pkg::RiseLimitReset;
      numerator = pred_pkg::NumeratorReset;
      prev_seen = '0;
      quiet_len = '0;
      idle_now = 1'b1;
      filter_ready = 1'b0;
      in_rise = 1'b0;
      rises = '0;
      falls = '0;
      ticks_since_beat = '0;
      rate_est = '0;
    end else begin
      if (in_valid && !in_stall) begin
        reading_q.push_back(predict_reading(sample));
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          sample <= sample_q.pop_front();
          in_valid <= 1'b1;
          gap_left = pick_gap(sender_free);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall: random stalls plus requested long hold-offs
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req != hold_done) begin
      hold_done++;
      hold_left = 300;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!receiver_free && $urandom_range(0, 3) == 0) stall_left = pick_gap(1'b0) + 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    reading_t want;
    if (!rst && out_valid && !out_stall) begin
      checked_count++;
      if (reading_q.size() == 0) begin
        report_mismatch("unexpected beat, rate_shown", rate_shown, 0);
      end else begin
        want = reading_q.pop_front();
        if (rate_shown !== want.rate_shown)
          report_mismatch("rate_shown", rate_shown, want.rate_shown);
        if (echo_valid !== want.echo_valid)
          report_mismatch("echo_valid", echo_valid, want.echo_valid);
        if (echo_sample !== want.echo_sample)
          report_mismatch("echo_sample", echo_sample, want.echo_sample);
        if (row_a !== want.row_a) report_mismatch("row_a", row_a, want.row_a);
        if (row_b !== want.row_b) report_mismatch("row_b", row_b, want.row_b);
        if (row_c !== want.row_c) report_mismatch("row_c", row_c, want.row_c);
        if (row_d !== want.row_d) report_mismatch("row_d", row_d, want.row_d);
        if (row_e !== want.row_e) report_mismatch("row_e", row_e, want.row_e);
      end
    end
  end

  function automatic void push_sample(input logic [15:0] v);
    sample_q.push_back(v);
    queued_count++;
  endfunction

  task automatic write_reg(input logic [pred_pkg::IndexW-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      pred_pkg::RegQuietLow:   band_low = val;
      pred_pkg::RegQuietHigh:  band_high = val;
      pred_pkg::RegIdleEnter:  enter_len = val[7:0];
      pred_pkg::RegIdleResume: resume_len = val[7:0];
      pred_pkg::RegFallLimit:  fall_lim = val[7:0];
      pred_pkg::RegRiseLimit:  rise_lim = val[7:0];
      pred_pkg::RegNumerator:  numerator = val;
      default: ;
    endcase
  endtask

  // pulse trains shaped by the current limits, with quiet stretches and noise
  task automatic queue_stream(input int n);
    int left, level, r, len, up_n, down_n, step_max;
    left = n;
    level = $urandom_range(0, 65535);
    while (left > 0) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) push_sample(16'($urandom_range(0, 65535)));
        left -= len;
      end else if (r < 18 && band_high > band_low + 16'd1) begin
        len = enter_len + 5;
        if (len > 300) len = 300;
        len = $urandom_range(1, len);
        for (int k = 0; k < len; k++)
          push_sample(16'($urandom_range(band_low + 1, band_high - 1)));
        left -= len;
      end else begin
        up_n = rise_lim + $urandom_range(1, 3);
        down_n = fall_lim + $urandom_range(1, 3);
        step_max = 60000 / (up_n + 1);
        if (step_max > 3000) step_max = 3000;
        if (step_max < 1) step_max = 1;
        for (int k = 0; k < up_n; k++) begin
          level = level + $urandom_range(1, step_max);
          if (level > 65535) level = 65535;
          push_sample(level[15:0]);
        end
        for (int k = 0; k < down_n; k++) begin
          level = level - $urandom_range(0, step_max);
          if (level < 0) level = 0;
          push_sample(level[15:0]);
        end
        left -= up_n + down_n;
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (accepted_count != queued_count || reading_q.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic run_phase(input logic [15:0] ql, input logic [15:0] qh,
                           input logic [7:0] ie, input logic [7:0] ir,
                           input logic [7:0] fl, input logic [7:0] rl,
                           input logic [15:0] num, input int n,
                           input bit hold, input bit tx_free, input bit rx_free);
    write_reg(pred_pkg::RegQuietLow, ql);
    write_reg(pred_pkg::RegQuietHigh, qh);
    write_reg(pred_pkg::RegIdleEnter, {8'd0, ie});
    write_reg(pred_pkg::RegIdleResume, {8'd0, ir});
    write_reg(pred_pkg::RegFallLimit, {8'd0, fl});
    write_reg(pred_pkg::RegRiseLimit, {8'd0, rl});
    write_reg(pred_pkg::RegNumerator, num);
    @(posedge clk);
    cfg_write_en <= 1'b0;
    sender_free <= tx_free;
    receiver_free <= rx_free;
    if (hold) hold_req <= hold_req + 1;
    settings_count++;
    @(negedge clk);
    queue_stream(n);
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (opening_samples[i]) push_sample(opening_samples[i]);
    queue_stream(200);
    wait_drained();

    run_phase(16'd20000, 16'd24000, 8'd12, 8'd4, 8'd2, 8'd3, 16'd900,
              200, 1'b1, 1'b1, 1'b0);
    // widest band, largest runs and numerator, smallest limits
    run_phase(16'd0, 16'd65535, 8'd255, 8'd255, 8'd0, 8'd0, 16'd65535,
              250, 1'b0, 1'b0, 1'b0);
    // empty band, zero numerator, falls never pass the top fall limit, so no beat
    run_phase(16'd65535, 16'd0, 8'd0, 8'd1, 8'd255, 8'd255, 16'd0,
              150, 1'b0, 1'b0, 1'b1);
    // always tracking, stuck in the rising phase as rises never pass the top rise limit
    run_phase(16'd65535, 16'd0, 8'd1, 8'd1, 8'd0, 8'd255, 16'd1,
              200, 1'b0, 1'b1, 1'b1);
    repeat (3) begin
      run_phase(16'($urandom_range(20000, 40000)), 16'($urandom_range(40002, 43000)),
                8'($urandom_range(1, 40)), 8'($urandom_range(0, 20)),
                8'($urandom_range(0, 8)), 8'($urandom_range(0, 10)),
                16'($urandom_range(1, 20000)), 200, 1'b1,
                1'($urandom_range(0, 1)), 1'b0);
    end
    run_phase(pred_pkg::QuietLowReset, pred_pkg::QuietHighReset,
              pred_pkg::IdleEnterReset, pred_pkg::IdleResumeReset,
              pred_pkg::FallLimitReset, pred_pkg::RiseLimitReset,
              pred_pkg::NumeratorReset, 200, 1'b0, 1'b0, 1'b0);

    repeat (30) @(posedge clk);
    if (reading_q.size() != 0) report_mismatch("results never seen", reading_q.size(), 0);
    $display("checked %0d results from %0d samples over %0d register settings",
             checked_count, accepted_count, settings_count);
    $display("beats timed %0d, readings with the hundreds dot %0d",
             beats_timed, dotted_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout: %0d samples accepted, %0d results checked",
             accepted_count, checked_count);
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> pulse_rate_estimator_display_core.f
+incdir+rtl/core
rtl/core/pred_pkg.sv
rtl/core/pred_ctrl.sv
rtl/core/pred_datapath.sv
rtl/core/pulse_rate_estimator_display_core.sv
tb/sv/tb.sv
